>>> rtl/cpi_pkg.sv
// Shared types and constants for the cube pattern index pipeline.
package cpi_pkg;

  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned NUM_EDGES   = 12;
  localparam int unsigned GROUP_SIZE  = 6;
  localparam int unsigned FLIP_BITS   = 5;
  localparam int unsigned GROUP_W     = 24;

  localparam logic [GROUP_W-1:0] GROUP_A_RESET = 24'd5517840;
  localparam logic [GROUP_W-1:0] GROUP_B_RESET = 24'd12228726;
  localparam logic [3:0]         MAX_SLOT      = 4'd11;
  localparam logic [26:0]        TWIST_STATES  = 27'd2187;

  typedef enum logic [0:0] {
    REG_GROUP_A = 1'b0,
    REG_GROUP_B = 1'b1
  } cpi_reg_e;

  // per-stage advance enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } cpi_adv_t;

  localparam logic [15:0] FACT7 [NUM_CORNERS] =
    '{16'd5040, 16'd720, 16'd120, 16'd24, 16'd6, 16'd2, 16'd1, 16'd1};
  localparam logic [9:0] FACT5 [GROUP_SIZE] =
    '{10'd120, 10'd24, 10'd6, 10'd2, 10'd1, 10'd1};
  // weight of twist digit i, position 0 most significant
  localparam logic [9:0] POW3 [NUM_CORNERS-1] =
    '{10'd729, 10'd243, 10'd81, 10'd27, 10'd9, 10'd3, 10'd1};

endpackage

>>> rtl/cpi_edge_group.sv
// Edge group index: slot select, rank normalize, Lehmer rank and flip bits.
module cpi_edge_group (
  input  logic                       clk_i,
  input  cpi_pkg::cpi_adv_t          adv_i,
  input  logic [cpi_pkg::GROUP_W-1:0] group_i,
  input  logic [47:0]                edge_perm_i,
  input  logic [11:0]                edge_ori_i,
  output logic                       bad_o,
  output logic [14:0]                index_o
);
  import cpi_pkg::*;

  logic [3:0] ep [NUM_EDGES];
  logic [3:0] val_d [GROUP_SIZE];
  logic [3:0] val_q [GROUP_SIZE];
  logic [FLIP_BITS-1:0] flip_d, flip_q, flip2_q;
  logic [2:0] nrm_d [GROUP_SIZE];
  logic [2:0] nrm_q [GROUP_SIZE];
  logic [9:0] rank;

  // slot select
  always_comb begin
    logic [3:0] slot;
    bad_o  = 1'b0;
    flip_d = '0;
    for (int i = 0; i < NUM_EDGES; i++) begin
      ep[i] = edge_perm_i[4*i +: 4];
    end
    for (int i = 0; i < GROUP_SIZE; i++) begin
      slot = group_i[4*i +: 4];
      if (slot > MAX_SLOT) begin
        bad_o = 1'b1;
        slot  = 4'd0;
      end
      val_d[i] = ep[slot];
      if (i < FLIP_BITS) begin
        flip_d[FLIP_BITS-1-i] = edge_ori_i[slot];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      val_q  <= val_d;
      flip_q <= flip_d;
    end
  end

  // rank within the group
  always_comb begin
    logic [2:0] cnt;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      cnt = 3'd0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (val_q[j] < val_q[i]) cnt = cnt + 3'd1;
      end
      nrm_d[i] = cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      nrm_q   <= nrm_d;
      flip2_q <= flip_q;
    end
  end

  // Lehmer rank of the normalized list
  always_comb begin
    logic [2:0] cnt;
    rank = 10'd0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      cnt = 3'd0;
      for (int j = i + 1; j < GROUP_SIZE; j++) begin
        if (nrm_q[j] < nrm_q[i]) cnt = cnt + 3'd1;
      end
      rank = rank + 10'(10'(cnt) * FACT5[i]);
    end
  end

  assign index_o = {rank, flip2_q};

endmodule

>>> rtl/cube_pattern_index_core.sv
// Cube pattern index core: corner and edge pattern-database indices, per cube state.
//
// Input channel: in_valid_i / in_ready_o carry one packed cube state per word
// (corner and edge permutations, twists and flips). Output channel:
// out_valid_o / out_ready_i carry one result word per input word, in order:
// corner index, edge group A and B indices, solved flag, edge bound, bad flag.
// out_valid_o rises once the word has passed the stage 1, 2 and 3 registers. With
// out_ready_i held high one word is accepted and one delivered every cycle.
// The three stages are: slot select and corner Lehmer counts, rank sums and
// group normalize, then the corner multiply-add and the group Lehmer rank into
// the output register. Each stage holds its word while the next one is full and
// stalled, so a stalled receiver fills the empty stages before in_ready_o drops.
// The edge groups are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write them only while the pipeline is empty, the block does not enforce it.
// Reset empties the pipeline and loads the default groups (slots 0..5 and 6..11).
module cube_pattern_index_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  cpi_pkg::cpi_reg_e           cfg_idx_i,
  input  logic [cpi_pkg::GROUP_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [23:0]                 corner_perm_i,
  input  logic [15:0]                 corner_ori_i,
  input  logic [47:0]                 edge_perm_i,
  input  logic [11:0]                 edge_ori_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [26:0]                 corner_index_o,
  output logic [14:0]                 edge_index_a_o,
  output logic [14:0]                 edge_index_b_o,
  output logic                        solved_o,
  output logic [1:0]                  edge_bound_o,
  output logic                        bad_input_o
);
  import cpi_pkg::*;

  cpi_adv_t adv;

  logic [GROUP_W-1:0] group_a_q, group_b_q;
  logic v1_q, v2_q, v3_q;

  // stage 1
  logic [2:0]  cp [NUM_CORNERS];
  logic [1:0]  co [NUM_CORNERS];
  logic [2:0]  lehmer_d [NUM_CORNERS];
  logic [2:0]  lehmer_q [NUM_CORNERS];
  logic [11:0] ccode_d, ccode_q, ccode2_q;
  logic [3:0]  wrong;
  logic        solved_d, solved_q, solved2_q;
  logic [1:0]  bound_d, bound_q, bound2_q;
  logic        bad_corner, bad_a, bad_b;
  logic        bad_q, bad2_q;

  // stage 2
  logic [15:0] crank_d, crank_q;

  // stage 3
  logic [14:0] idx_a, idx_b;
  logic [26:0] cidx;
  logic [26:0] corner_index_q;
  logic [14:0] edge_index_a_q, edge_index_b_q;
  logic        solved3_q, bad3_q;
  logic [1:0]  bound3_q;

  assign adv.s3     = !v3_q || out_ready_i;
  assign adv.s2     = !v2_q || adv.s3;
  assign adv.s1     = !v1_q || adv.s2;
  assign in_ready_o = adv.s1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_a_q <= GROUP_A_RESET;
      group_b_q <= GROUP_B_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GROUP_A: group_a_q <= cfg_wdata_i;
        REG_GROUP_B: group_b_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv.s1) v1_q <= in_valid_i;
      if (adv.s2) v2_q <= v1_q;
      if (adv.s3) v3_q <= v2_q;
    end
  end

  // stage 1: corner Lehmer digits, twist code, edge checks
  always_comb begin
    logic [2:0] cnt;
    bad_corner = 1'b0;
    solved_d   = 1'b1;
    ccode_d    = 12'd0;
    wrong      = 4'd0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      cp[i] = corner_perm_i[3*i +: 3];
      co[i] = corner_ori_i[2*i +: 2];
    end
    for (int i = 0; i < NUM_CORNERS; i++) begin
      cnt = 3'd0;
      for (int j = i + 1; j < NUM_CORNERS; j++) begin
        if (cp[j] < cp[i]) cnt = cnt + 3'd1;
      end
      lehmer_d[i] = cnt;
      if (co[i] == 2'd3) bad_corner = 1'b1;
      if (cp[i] != 3'(i) || co[i] != 2'd0) solved_d = 1'b0;
    end
    for (int i = 0; i < NUM_CORNERS - 1; i++) begin
      ccode_d = ccode_d + 12'(12'(co[i]) * 12'(POW3[i]));
    end
    for (int i = 0; i < NUM_EDGES; i++) begin
      if (edge_perm_i[4*i +: 4] != 4'(i) || edge_ori_i[i]) wrong = wrong + 4'd1;
    end
    if (wrong != 4'd0) solved_d = 1'b0;
    bound_d = 2'((5'(wrong) + 5'd3) >> 2);
  end

  cpi_edge_group u_group_a (
    .clk_i       (clk_i),
    .adv_i       (adv),
    .group_i     (group_a_q),
    .edge_perm_i (edge_perm_i),
    .edge_ori_i  (edge_ori_i),
    .bad_o       (bad_a),
    .index_o     (idx_a)
  );

  cpi_edge_group u_group_b (
    .clk_i       (clk_i),
    .adv_i       (adv),
    .group_i     (group_b_q),
    .edge_perm_i (edge_perm_i),
    .edge_ori_i  (edge_ori_i),
    .bad_o       (bad_b),
    .index_o     (idx_b)
  );

  always_ff @(posedge clk_i) begin
    if (adv.s1) begin
      lehmer_q <= lehmer_d;
      ccode_q  <= ccode_d;
      solved_q <= solved_d;
      bound_q  <= bound_d;
      bad_q    <= bad_corner || bad_a || bad_b;
    end
  end

  // stage 2: corner rank
  always_comb begin
    crank_d = 16'd0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      crank_d = crank_d + 16'(16'(lehmer_q[i]) * FACT7[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv.s2) begin
      crank_q   <= crank_d;
      ccode2_q  <= ccode_q;
      solved2_q <= solved_q;
      bound2_q  <= bound_q;
      bad2_q    <= bad_q;
    end
  end

  // stage 3: corner index, zeroing on bad input
  assign cidx = 27'(27'(crank_q) * TWIST_STATES) + 27'(ccode2_q);

  always_ff @(posedge clk_i) begin
    if (adv.s3) begin
      corner_index_q <= bad2_q ? 27'd0 : cidx;
      edge_index_a_q <= bad2_q ? 15'd0 : idx_a;
      edge_index_b_q <= bad2_q ? 15'd0 : idx_b;
      solved3_q      <= solved2_q;
      bound3_q       <= bound2_q;
      bad3_q         <= bad2_q;
    end
  end

  assign out_valid_o    = v3_q;
  assign corner_index_o = corner_index_q;
  assign edge_index_a_o = edge_index_a_q;
  assign edge_index_b_o = edge_index_b_q;
  assign solved_o       = solved3_q;
  assign edge_bound_o   = bound3_q;
  assign bad_input_o    = bad3_q;

  a_bad_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_input_o |->
      corner_index_o == 27'd0 && edge_index_a_o == 15'd0 && edge_index_b_o == 15'd0)
    else $error("bad word with nonzero index");

  a_solved_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && solved_o |-> edge_bound_o == 2'd0)
    else $error("solved word with nonzero edge bound");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && v1_q && v2_q)
    else $error("input stalled with room in the pipeline");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> edge_index_a_o <= 15'd23039 && edge_index_b_o <= 15'd23039)
    else $error("edge index out of range");

endmodule
